### design/lavm_pkg.sv
`timescale 1ns / 1ps
package lavm_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int UNIT_FRAC  = 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = UNIT_FRAC + 1;
  localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [33:0] comp_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] row_x;
    logic signed [31:0] row_y;
    logic signed [31:0] row_z;
    logic signed [31:0] row_shift;
    logic               last_row;
    logic               degenerate;
  } out_word_t;

endpackage

### design/lavm_norm.sv
`timescale 1ns / 1ps
module lavm_norm
  import lavm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vec_valid,
  input  comp_t vec [3],
  output logic  unit_valid,
  output s32_t  unit_vec [3]
);

  localparam int QW = DIV_STEPS;

  logic [33:0]   mag_nxt [3];

  logic          v0_r;
  logic          neg0_r [3];
  logic [33:0]   mag0_r [3];
  logic [63:0]   sq0_r  [3];

  logic          sv_r   [SQRT_STEPS+1];
  logic [63:0]   sx_r   [SQRT_STEPS+1];
  logic [63:0]   sres_r [SQRT_STEPS+1];
  logic          sneg_r [SQRT_STEPS+1][3];
  logic [33:0]   smag_r [SQRT_STEPS+1][3];
  logic [63:0]   strial [SQRT_STEPS];

  logic          dv_r   [DIV_STEPS+1];
  logic [31:0]   ds_r   [DIV_STEPS+1];
  logic [63:0]   drem_r [DIV_STEPS+1][3];
  logic [QW-1:0] dq_r   [DIV_STEPS+1][3];
  logic          dneg_r [DIV_STEPS+1][3];
  logic [63:0]   dsub   [DIV_STEPS];
  s32_t          qext   [3];

  logic          uv_r;
  s32_t          u_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = vec[i][33] ? 34'(-vec[i]) : 34'(vec[i]);
      qext[i]    = 32'(dq_r[DIV_STEPS][i]);
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      strial[k] = sres_r[k] + (64'd1 << (2 * (SQRT_STEPS - 1 - k)));
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      dsub[k] = 64'(ds_r[k]) << (DIV_STEPS - 1 - k);
    end
  end

  // squares, sum, one root bit per stage, one quotient bit per stage, sign restore
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= vec[i][33];
        mag0_r[i] <= mag_nxt[i];
        sq0_r[i]  <= 64'(mag_nxt[i] * mag_nxt[i]);
        sneg_r[0][i] <= neg0_r[i];
        smag_r[0][i] <= mag0_r[i];
      end
      sx_r[0]   <= sq0_r[0] + sq0_r[1] + sq0_r[2];
      sres_r[0] <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        if (sx_r[k] >= strial[k]) begin
          sx_r[k+1]   <= sx_r[k] - strial[k];
          sres_r[k+1] <= (sres_r[k] >> 1) + (64'd1 << (2 * (SQRT_STEPS - 1 - k)));
        end else begin
          sx_r[k+1]   <= sx_r[k];
          sres_r[k+1] <= sres_r[k] >> 1;
        end
        for (int i = 0; i < 3; i++) begin
          sneg_r[k+1][i] <= sneg_r[k][i];
          smag_r[k+1][i] <= smag_r[k][i];
        end
      end
      ds_r[0] <= sres_r[SQRT_STEPS][31:0];
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= (64'(smag_r[SQRT_STEPS][i]) << UNIT_FRAC)
                        + 64'(sres_r[SQRT_STEPS][31:1]);
        dq_r[0][i]   <= '0;
        dneg_r[0][i] <= sneg_r[SQRT_STEPS][i];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        ds_r[k+1] <= ds_r[k];
        for (int i = 0; i < 3; i++) begin
          dneg_r[k+1][i] <= dneg_r[k][i];
          if (drem_r[k][i] >= dsub[k]) begin
            drem_r[k+1][i] <= drem_r[k][i] - dsub[k];
            dq_r[k+1][i]   <= dq_r[k][i] | (QW'(1) << (DIV_STEPS - 1 - k));
          end else begin
            drem_r[k+1][i] <= drem_r[k][i];
            dq_r[k+1][i]   <= dq_r[k][i];
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= dneg_r[DIV_STEPS][i] ? -qext[i] : qext[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k] <= 1'b0;
      uv_r <= 1'b0;
    end else if (en) begin
      v0_r    <= vec_valid;
      sv_r[0] <= v0_r;
      for (int k = 0; k < SQRT_STEPS; k++) sv_r[k+1] <= sv_r[k];
      dv_r[0] <= sv_r[SQRT_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k+1] <= dv_r[k];
      uv_r    <= dv_r[DIV_STEPS];
    end
  end

  assign unit_valid = uv_r;
  assign unit_vec   = u_r;

endmodule

### design/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// Look-at view matrix unit. Each input word is one camera (position, look
// direction, up hint, signed Q16.16); it yields three output words in turn,
// rows u, v and w of the view matrix with their translations, the last one
// flagged by last_row. Cameras enter one per cycle while the pipeline advances,
// into a fully pipelined datapath with two normalizers (32-stage root, 31-stage
// divider each). The single output channel limits sustained throughput: the
// pipeline holds while a camera's rows go out, and a stall on a waiting output
// word holds it too.
module look_at_view_matrix_unit
  import lavm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int         ELEM_SH  = UNIT_FRAC - FRAC_BITS;
  localparam logic [1:0] LAST_ROW = 2'd2;

  typedef logic signed [35:0] s36_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [67:0] s68_t;
  typedef logic signed [71:0] s72_t;

  function automatic s72_t rnd_sh(input s72_t x, input int k);
    logic [71:0] mag;
    logic [71:0] q;
    mag = x[71] ? 72'(-x) : 72'(x);
    q   = (mag + (72'd1 << (k - 1))) >> k;
    return x[71] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [4:0] pre_sh(input logic [35:0] mag);
    logic [4:0] s;
    s = 5'd0;
    for (int i = 0; i < UNIT_FRAC; i++) begin
      if (mag[i]) s = 5'(UNIT_FRAC - i);
    end
    if (mag >= (36'd1 << UNIT_FRAC)) s = 5'd0;
    return s;
  endfunction

  function automatic logic [35:0] mag36(input s36_t x);
    return x[35] ? 36'(-x) : 36'(x);
  endfunction

  function automatic logic [35:0] max3(input logic [35:0] a, input logic [35:0] b,
                                       input logic [35:0] c);
    logic [35:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  logic adv, out_fire;

  // stage A
  logic     vld_a_r;
  in_word_t ina_r;
  s32_t     pa [3], la [3], ua [3];
  // stage B
  logic        vld_b_r;
  s32_t        posb_r [3], lkb_r [3], upb_r [3];
  s64_t        cpb_r [6];
  logic [35:0] mla_r, mlb_r;
  // stage C
  logic       vld_c_r, parc_r;
  s32_t       posc_r [3], lkc_r [3], upc_r [3];
  logic [4:0] sha_r, shb_r;
  // stage D
  logic  vld_d_r, pard_r;
  s32_t  posd_r [3];
  comp_t ad_r [3], bd_r [3];
  // first normalizer and its side line
  logic  n1_v;
  s32_t  n1_u [3];
  logic  dl1_v_r   [NORM_LAT];
  logic  dl1_par_r [NORM_LAT];
  s32_t  dl1_pos_r [NORM_LAT][3];
  comp_t dl1_b_r   [NORM_LAT][3];
  // stages E..K
  logic  vld_e_r, pare_r;
  s32_t  we_r [3], pose_r [3];
  comp_t be_r [3];
  logic  vld_f_r, parf_r;
  s32_t  wf_r [3], posf_r [3];
  comp_t bf_r [3];
  s68_t  bwf_r [3];
  logic  vld_g_r, parg_r;
  s32_t  wg_r [3], posg_r [3];
  comp_t bg_r [3];
  s36_t  dg_r;
  logic  vld_h_r, parh_r;
  s32_t  wh_r [3], posh_r [3];
  comp_t bh_r [3];
  s68_t  dwh_r [3];
  logic  vld_i_r, pari_r;
  s32_t  wi_r [3], posi_r [3];
  s36_t  pi_r [3];
  logic        vld_j_r, parj_r, pzj_r;
  s32_t        wj_r [3], posj_r [3];
  s36_t        pj_r [3];
  logic [4:0]  spj_r;
  logic  vld_k_r, dgk_r;
  s32_t  wk_r [3], posk_r [3];
  comp_t pk_r [3];
  s36_t  pshift [3];
  // second normalizer and its side line
  logic  n2_v;
  s32_t  n2_u [3];
  logic  dl2_v_r   [NORM_LAT];
  logic  dl2_dg_r  [NORM_LAT];
  s32_t  dl2_w_r   [NORM_LAT][3];
  s32_t  dl2_pos_r [NORM_LAT][3];
  // stages L..O
  logic  vld_l_r, dgl_r;
  s32_t  vl_r [3], wl_r [3], posl_r [3];
  s64_t  cpl_r [6];
  logic  vld_m_r, dgm_r;
  s32_t  um_r [3], vm_r [3], wm_r [3], posm_r [3];
  s32_t  rowm [3][3];
  logic  vld_n_r, dgn_r;
  s32_t  eln_r [3][3];
  s64_t  rpn_r [3][3];
  logic  vld_o_r, dgo_r;
  s32_t  elo_r [3][3];
  s32_t  sho_r [3];
  s72_t  acc_nxt [3];
  s72_t  tr_nxt [3];
  s32_t  sh_nxt [3];
  // row serializer
  logic       ser_v_r, ser_dg_r;
  logic [1:0] cnt_r;
  s32_t       ser_el_r [3][3];
  s32_t       ser_sh_r [3];

  assign out_fire = ser_v_r && !out_stall;
  assign adv      = !ser_v_r || (out_fire && cnt_r == LAST_ROW);
  assign in_stall = !adv;

  always_comb begin
    pa = '{ina_r.pos_x, ina_r.pos_y, ina_r.pos_z};
    la = '{ina_r.look_x, ina_r.look_y, ina_r.look_z};
    ua = '{ina_r.up_x, ina_r.up_y, ina_r.up_z};
    for (int i = 0; i < 3; i++) begin
      pshift[i] = pj_r[i] <<< spj_r;
      rowm[0][i] = um_r[i];
      rowm[1][i] = vm_r[i];
      rowm[2][i] = wm_r[i];
    end
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = 72'(rpn_r[r][0]) + 72'(rpn_r[r][1]) + 72'(rpn_r[r][2]);
      tr_nxt[r]  = -rnd_sh(acc_nxt[r], UNIT_FRAC);
      if (tr_nxt[r] > 72'sd2147483647) begin
        sh_nxt[r] = 32'sh7fffffff;
      end else if (tr_nxt[r] < -72'sd2147483648) begin
        sh_nxt[r] = 32'sh80000000;
      end else begin
        sh_nxt[r] = tr_nxt[r][31:0];
      end
    end
  end

  lavm_norm u_norm_look (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .vec_valid  (vld_d_r),
    .vec        (ad_r),
    .unit_valid (n1_v),
    .unit_vec   (n1_u)
  );

  lavm_norm u_norm_up (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .vec_valid  (vld_k_r),
    .vec        (pk_r),
    .unit_valid (n2_v),
    .unit_vec   (n2_u)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ina_r <= in_data;
      // B: parallel test products, largest magnitudes
      for (int i = 0; i < 3; i++) begin
        posb_r[i] <= pa[i];
        lkb_r[i]  <= la[i];
        upb_r[i]  <= ua[i];
      end
      cpb_r[0] <= 64'(la[1]) * 64'(ua[2]);
      cpb_r[1] <= 64'(la[2]) * 64'(ua[1]);
      cpb_r[2] <= 64'(la[2]) * 64'(ua[0]);
      cpb_r[3] <= 64'(la[0]) * 64'(ua[2]);
      cpb_r[4] <= 64'(la[0]) * 64'(ua[1]);
      cpb_r[5] <= 64'(la[1]) * 64'(ua[0]);
      mla_r <= max3(mag36(36'(la[0])), mag36(36'(la[1])), mag36(36'(la[2])));
      mlb_r <= max3(mag36(36'(ua[0])), mag36(36'(ua[1])), mag36(36'(ua[2])));
      // C
      posc_r <= posb_r;
      lkc_r  <= lkb_r;
      upc_r  <= upb_r;
      parc_r <= (cpb_r[0] == cpb_r[1]) && (cpb_r[2] == cpb_r[3]) && (cpb_r[4] == cpb_r[5]);
      sha_r  <= pre_sh(mla_r);
      shb_r  <= pre_sh(mlb_r);
      // D: prescale
      posd_r <= posc_r;
      pard_r <= parc_r;
      for (int i = 0; i < 3; i++) begin
        ad_r[i] <= 34'(lkc_r[i]) <<< sha_r;
        bd_r[i] <= 34'(upc_r[i]) <<< shb_r;
      end
      // side line across the first normalizer
      dl1_par_r[0] <= pard_r;
      dl1_pos_r[0] <= posd_r;
      dl1_b_r[0]   <= bd_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl1_par_r[k] <= dl1_par_r[k-1];
        dl1_pos_r[k] <= dl1_pos_r[k-1];
        dl1_b_r[k]   <= dl1_b_r[k-1];
      end
      // E: w is the negated unit look
      for (int i = 0; i < 3; i++) we_r[i] <= -n1_u[i];
      be_r   <= dl1_b_r[NORM_LAT-1];
      pose_r <= dl1_pos_r[NORM_LAT-1];
      pare_r <= dl1_par_r[NORM_LAT-1];
      // F
      for (int i = 0; i < 3; i++) bwf_r[i] <= 68'(be_r[i]) * 68'(we_r[i]);
      wf_r <= we_r; bf_r <= be_r; posf_r <= pose_r; parf_r <= pare_r;
      // G
      dg_r <= 36'(rnd_sh(72'(bwf_r[0]) + 72'(bwf_r[1]) + 72'(bwf_r[2]), UNIT_FRAC));
      wg_r <= wf_r; bg_r <= bf_r; posg_r <= posf_r; parg_r <= parf_r;
      // H
      for (int i = 0; i < 3; i++) dwh_r[i] <= 68'(dg_r) * 68'(wg_r[i]);
      wh_r <= wg_r; bh_r <= bg_r; posh_r <= posg_r; parh_r <= parg_r;
      // I: part of up orthogonal to w
      for (int i = 0; i < 3; i++) begin
        pi_r[i] <= 36'(bh_r[i]) - 36'(rnd_sh(72'(dwh_r[i]), UNIT_FRAC));
      end
      wi_r <= wh_r; posi_r <= posh_r; pari_r <= parh_r;
      // J
      pj_r  <= pi_r;
      spj_r <= pre_sh(max3(mag36(pi_r[0]), mag36(pi_r[1]), mag36(pi_r[2])));
      pzj_r <= (pi_r[0] == '0) && (pi_r[1] == '0) && (pi_r[2] == '0);
      wj_r <= wi_r; posj_r <= posi_r; parj_r <= pari_r;
      // K
      for (int i = 0; i < 3; i++) pk_r[i] <= pshift[i][33:0];
      dgk_r <= parj_r || pzj_r;
      wk_r <= wj_r; posk_r <= posj_r;
      // side line across the second normalizer
      dl2_dg_r[0]  <= dgk_r;
      dl2_w_r[0]   <= wk_r;
      dl2_pos_r[0] <= posk_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl2_dg_r[k]  <= dl2_dg_r[k-1];
        dl2_w_r[k]   <= dl2_w_r[k-1];
        dl2_pos_r[k] <= dl2_pos_r[k-1];
      end
      // L: u = v x w products
      vl_r   <= n2_u;
      wl_r   <= dl2_w_r[NORM_LAT-1];
      posl_r <= dl2_pos_r[NORM_LAT-1];
      dgl_r  <= dl2_dg_r[NORM_LAT-1];
      cpl_r[0] <= 64'(n2_u[1]) * 64'(dl2_w_r[NORM_LAT-1][2]);
      cpl_r[1] <= 64'(n2_u[2]) * 64'(dl2_w_r[NORM_LAT-1][1]);
      cpl_r[2] <= 64'(n2_u[2]) * 64'(dl2_w_r[NORM_LAT-1][0]);
      cpl_r[3] <= 64'(n2_u[0]) * 64'(dl2_w_r[NORM_LAT-1][2]);
      cpl_r[4] <= 64'(n2_u[0]) * 64'(dl2_w_r[NORM_LAT-1][1]);
      cpl_r[5] <= 64'(n2_u[1]) * 64'(dl2_w_r[NORM_LAT-1][0]);
      // M
      for (int i = 0; i < 3; i++) begin
        um_r[i] <= 32'(rnd_sh(72'(cpl_r[2*i]) - 72'(cpl_r[2*i+1]), UNIT_FRAC));
      end
      vm_r <= vl_r; wm_r <= wl_r; posm_r <= posl_r; dgm_r <= dgl_r;
      // N: element rounding and translation products
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          eln_r[r][i] <= 32'(rnd_sh(72'(rowm[r][i]), ELEM_SH));
          rpn_r[r][i] <= 64'(rowm[r][i]) * 64'(posm_r[i]);
        end
      end
      dgn_r <= dgm_r;
      // O
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) elo_r[r][i] <= dgn_r ? '0 : eln_r[r][i];
        sho_r[r] <= dgn_r ? '0 : sh_nxt[r];
      end
      dgo_r <= dgn_r;
      // serializer load
      ser_el_r <= elo_r;
      ser_sh_r <= sho_r;
      ser_dg_r <= dgo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0; vld_b_r <= 1'b0; vld_c_r <= 1'b0; vld_d_r <= 1'b0;
      vld_e_r <= 1'b0; vld_f_r <= 1'b0; vld_g_r <= 1'b0; vld_h_r <= 1'b0;
      vld_i_r <= 1'b0; vld_j_r <= 1'b0; vld_k_r <= 1'b0; vld_l_r <= 1'b0;
      vld_m_r <= 1'b0; vld_n_r <= 1'b0; vld_o_r <= 1'b0;
      for (int k = 0; k < NORM_LAT; k++) begin
        dl1_v_r[k] <= 1'b0;
        dl2_v_r[k] <= 1'b0;
      end
      ser_v_r <= 1'b0;
      cnt_r   <= '0;
    end else if (adv) begin
      vld_a_r <= in_valid; vld_b_r <= vld_a_r; vld_c_r <= vld_b_r; vld_d_r <= vld_c_r;
      dl1_v_r[0] <= vld_d_r;
      dl2_v_r[0] <= vld_k_r;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl1_v_r[k] <= dl1_v_r[k-1];
        dl2_v_r[k] <= dl2_v_r[k-1];
      end
      vld_e_r <= n1_v;    vld_f_r <= vld_e_r; vld_g_r <= vld_f_r; vld_h_r <= vld_g_r;
      vld_i_r <= vld_h_r; vld_j_r <= vld_i_r; vld_k_r <= vld_j_r;
      vld_l_r <= n2_v;    vld_m_r <= vld_l_r; vld_n_r <= vld_m_r; vld_o_r <= vld_n_r;
      ser_v_r <= vld_o_r;
      cnt_r   <= '0;
    end else if (out_fire) begin
      cnt_r <= cnt_r + 2'd1;
    end
  end

  assign out_valid = ser_v_r;

  always_comb begin
    out_data.row_index  = cnt_r;
    out_data.row_x      = ser_el_r[cnt_r][0];
    out_data.row_y      = ser_el_r[cnt_r][1];
    out_data.row_z      = ser_el_r[cnt_r][2];
    out_data.row_shift  = ser_sh_r[cnt_r];
    out_data.last_row   = (cnt_r == LAST_ROW);
    out_data.degenerate = ser_dg_r;
  end

  a_norm1_align: assert property (@(posedge clk) disable iff (!rst_n)
    n1_v == dl1_v_r[NORM_LAT-1])
    else $error("look normalizer out of step with side line");

  a_norm2_align: assert property (@(posedge clk) disable iff (!rst_n)
    n2_v == dl2_v_r[NORM_LAT-1])
    else $error("up normalizer out of step with side line");

  a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.last_row |=>
      out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
    else $error("row sequence broken");

  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_row |-> in_stall)
    else $error("pipeline moved during a row run");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.row_x == '0 && out_data.row_y == '0 &&
      out_data.row_z == '0 && out_data.row_shift == '0)
    else $error("degenerate word carries data");

endmodule

### dv/look_at_view_matrix_checker.sv
`timescale 1ns / 1ps
module look_at_view_matrix_checker
  import lavm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        mismatches,
  output int        rows_pending
);

  typedef logic signed [127:0] big_t;

  localparam big_t ONE30 = big_t'(1) <<< UNIT_FRAC;

  out_word_t expected_rows[$];

  function automatic big_t mag(input big_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic big_t round_div(input big_t n, input big_t d);
    big_t q;
    if (d == 0) return 0;
    q = (mag(n) + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic big_t floor_sqrt(input big_t x);
    big_t res;
    big_t b;
    big_t r;
    res = 0;
    r = x;
    b = big_t'(1) <<< 62;
    while (b > r) b = b >>> 2;
    while (b != 0) begin
      if (r >= res + b) begin
        r = r - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic bit scale_up(inout big_t c0, inout big_t c1, inout big_t c2);
    big_t m;
    m = mag(c0);
    if (mag(c1) > m) m = mag(c1);
    if (mag(c2) > m) m = mag(c2);
    if (m == 0) return 1'b0;
    while (m < ONE30) begin
      c0 = c0 * 2;
      c1 = c1 * 2;
      c2 = c2 * 2;
      m = m * 2;
    end
    return 1'b1;
  endfunction

  function automatic void to_unit(input big_t c0, input big_t c1, input big_t c2,
                                  output big_t o0, output big_t o1, output big_t o2);
    big_t s;
    s = floor_sqrt(c0 * c0 + c1 * c1 + c2 * c2);
    o0 = round_div(c0 * ONE30, s);
    o1 = round_div(c1 * ONE30, s);
    o2 = round_div(c2 * ONE30, s);
  endfunction

  function automatic big_t sat32(input big_t x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic predict_rows(input in_word_t cam, output out_word_t rows[3]);
    big_t pos[3], lk[3], up[3], a[3], b[3], p[3], w[3], v[3], u[3], basis[3][3];
    big_t d, acc;
    bit degen;
    pos[0] = cam.pos_x;  pos[1] = cam.pos_y;  pos[2] = cam.pos_z;
    lk[0]  = cam.look_x; lk[1]  = cam.look_y; lk[2]  = cam.look_z;
    up[0]  = cam.up_x;   up[1]  = cam.up_y;   up[2]  = cam.up_z;
    a = lk;
    b = up;
    degen = (lk[1] * up[2] == lk[2] * up[1]) && (lk[2] * up[0] == lk[0] * up[2]) &&
            (lk[0] * up[1] == lk[1] * up[0]);
    if (!degen && scale_up(a[0], a[1], a[2]) && scale_up(b[0], b[1], b[2])) begin
      to_unit(a[0], a[1], a[2], w[0], w[1], w[2]);
      d = 0;
      for (int i = 0; i < 3; i++) begin
        w[i] = -w[i];
        d = d + b[i] * w[i];
      end
      d = round_div(d, ONE30);
      for (int i = 0; i < 3; i++) p[i] = b[i] - round_div(d * w[i], ONE30);
      if (!scale_up(p[0], p[1], p[2])) begin
        degen = 1'b1;
      end else begin
        to_unit(p[0], p[1], p[2], v[0], v[1], v[2]);
        u[0] = round_div(v[1] * w[2] - v[2] * w[1], ONE30);
        u[1] = round_div(v[2] * w[0] - v[0] * w[2], ONE30);
        u[2] = round_div(v[0] * w[1] - v[1] * w[0], ONE30);
      end
    end else begin
      degen = 1'b1;
    end
    basis[0] = u;
    basis[1] = v;
    basis[2] = w;
    for (int k = 0; k < 3; k++) begin
      rows[k] = '0;
      rows[k].row_index  = 2'(k);
      rows[k].last_row   = (k == 2);
      rows[k].degenerate = degen;
      if (!degen) begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc = acc + basis[k][i] * pos[i];
        rows[k].row_x     = 32'(round_div(basis[k][0], big_t'(1) <<< (UNIT_FRAC - FRAC_BITS)));
        rows[k].row_y     = 32'(round_div(basis[k][1], big_t'(1) <<< (UNIT_FRAC - FRAC_BITS)));
        rows[k].row_z     = 32'(round_div(basis[k][2], big_t'(1) <<< (UNIT_FRAC - FRAC_BITS)));
        rows[k].row_shift = 32'(sat32(-round_div(acc, ONE30)));
      end
    end
  endtask

  initial mismatches = 0;

  assign rows_pending = expected_rows.size();

  always @(posedge clk) begin
    out_word_t rows[3];
    out_word_t exp_row;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_rows(in_data, rows);
        for (int k = 0; k < 3; k++) expected_rows.push_back(rows[k]);
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected output word %h", out_data);
        end else begin
          exp_row = expected_rows.pop_front();
          if (out_data.row_index !== exp_row.row_index || out_data.row_x !== exp_row.row_x ||
              out_data.row_y !== exp_row.row_y || out_data.row_z !== exp_row.row_z ||
              out_data.row_shift !== exp_row.row_shift ||
              out_data.last_row !== exp_row.last_row ||
              out_data.degenerate !== exp_row.degenerate) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("row mismatch: exp idx %0d x %0d y %0d z %0d t %0d last %0b deg %0b",
                       exp_row.row_index, exp_row.row_x, exp_row.row_y, exp_row.row_z,
                       exp_row.row_shift, exp_row.last_row, exp_row.degenerate,
                       "\n              got idx %0d x %0d y %0d z %0d t %0d last %0b deg %0b",
                       out_data.row_index, out_data.row_x, out_data.row_y, out_data.row_z,
                       out_data.row_shift, out_data.last_row, out_data.degenerate);
          end
        end
      end
    end
  end

endmodule

### dv/look_at_view_matrix_unit_test.sv
`timescale 1ns / 1ps
module look_at_view_matrix_unit_test;
  import lavm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 80;
  localparam int DRAIN_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        mismatches;
  int        rows_pending;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        quiet_cycles = 0;

  always #1 clk = ~clk;

  look_at_view_matrix_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  look_at_view_matrix_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .mismatches(mismatches), .rows_pending(rows_pending)
  );

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_camera(input in_word_t cam);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cam;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_vectors(input s32_t px, py, pz, lx, ly, lz, ux, uy, uz);
    in_word_t cam;
    cam = '{px, py, pz, lx, ly, lz, ux, uy, uz};
    send_camera(cam);
  endtask

  function automatic s32_t rnd_comp(input int mode);
    case (mode)
      0: return s32_t'($urandom);
      1: return s32_t'($urandom_range(16'hffff << 4)) - s32_t'(16'hffff << 3);
      default: return s32_t'($urandom_range(32'h4_0000)) - s32_t'(32'h2_0000);
    endcase
  endfunction

  task automatic send_random_camera();
    in_word_t cam;
    int mode;
    int kind;
    s32_t k;
    mode = $urandom_range(2);
    kind = $urandom_range(19);
    cam.pos_x  = rnd_comp(mode); cam.pos_y  = rnd_comp(mode); cam.pos_z  = rnd_comp(mode);
    cam.look_x = rnd_comp(mode); cam.look_y = rnd_comp(mode); cam.look_z = rnd_comp(mode);
    cam.up_x   = rnd_comp(mode); cam.up_y   = rnd_comp(mode); cam.up_z   = rnd_comp(mode);
    if (kind == 0) begin
      cam.look_x = 0; cam.look_y = 0; cam.look_z = 0;
    end else if (kind == 1) begin
      k = s32_t'($urandom_range(7)) - 3;
      cam.look_x = rnd_comp(2); cam.look_y = rnd_comp(2); cam.look_z = rnd_comp(2);
      cam.up_x = cam.look_x * k; cam.up_y = cam.look_y * k; cam.up_z = cam.look_z * k;
    end else if (kind == 2) begin
      cam.up_x = cam.look_x; cam.up_y = cam.look_y; cam.up_z = cam.look_z + 1;
    end
    send_camera(cam);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 8;
    rx_idle_pct = 56;
    send_vectors(0, 0, 32'sh5_0000, 0, 0, -32'sh1_0000, 0, 32'sh1_0000, 0);
    send_vectors(32'sh1_0000, 32'sh2_0000, 32'sh3_0000, 32'sh1_0000, 0, 0, 0, 0, 32'sh1_0000);
    send_vectors(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -32'sh1_0000, 0, 0,
                 0, 32'sh1_0000, 0);
    send_vectors(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh1_0000, 0, 0,
                 0, 32'sh1_0000, 0);
    send_vectors(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
    send_vectors(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vectors(1, -1, 1, 1, 0, 0, 0, 1, 0);
    send_vectors(-1, 1, -1, 0, -1, 0, 1, 0, 1);
    send_vectors(32'sh1_0000, 0, 0, 0, 0, 0, 0, 32'sh1_0000, 0);
    send_vectors(32'sh1_0000, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 32'sh2_0000, 32'sh2_0000, 0);
    send_vectors(0, 0, 0, 32'sh1_0000, 0, 0, -32'sh3_0000, 0, 0);
    send_vectors(5, 6, 7, 32'sh1_0000, 0, 0, 0, 0, 0);
    send_vectors(0, 0, 0, 32'sh7fffffff, 0, 0, 32'sh7fffffff, 1, 0);
    send_vectors(0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7ffffffe, 0);
    send_vectors(0, 0, 0, 32'sh80000000, 1, 0, 32'sh80000000, 0, 1);
    send_vectors(32'sh12345678, -32'sh0abcdef0, 32'sh00ff00ff, 3, 4, 5, -2, 7, 1);
    send_vectors(32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000, 1, 1, 1, 0, 0, 1);

    for (int n = 0; n < PHASE_ITEMS; n++) send_random_camera();

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    tx_idle_pct = 56;
    rx_idle_pct = 8;
    for (int n = 0; n < PHASE_ITEMS; n++) send_random_camera();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < PHASE_ITEMS + 5; n++) send_random_camera();

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && rows_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
